>>> src/bcpo_pkg.sv
// Shared types, constants and helpers for the box collision push-out block.
// No dependencies; used by every module under src.
package bcpo_pkg;

   // Field widths
   localparam int COORD_WIDTH   = 16;
   localparam int FRACTION_BITS = 8;
   localparam int SIZE_WIDTH    = COORD_WIDTH - 1;
   localparam int DIFF_WIDTH    = COORD_WIDTH + 1;           // center difference
   localparam int PROD_WIDTH    = DIFF_WIDTH + SIZE_WIDTH + 1; // dy*wA, hA*dx
   localparam int RAW_WIDTH     = COORD_WIDTH + 2;           // unsaturated target

   // Padding register reset: 0.1 rounded to nearest
   localparam logic [SIZE_WIDTH-1:0] PAD_RESET =
      SIZE_WIDTH'(((1 << FRACTION_BITS) + 5) / 10);

   // Push side codes
   localparam logic [2:0] SIDE_NONE  = 3'd0;
   localparam logic [2:0] SIDE_ABOVE = 3'd1;
   localparam logic [2:0] SIDE_LEFT  = 3'd2;
   localparam logic [2:0] SIDE_RIGHT = 3'd3;
   localparam logic [2:0] SIDE_BELOW = 3'd4;

   typedef struct packed {
      logic signed [COORD_WIDTH-1:0] a_center_x;
      logic signed [COORD_WIDTH-1:0] a_center_y;
      logic        [SIZE_WIDTH-1:0]  a_width;
      logic        [SIZE_WIDTH-1:0]  a_height;
      logic signed [COORD_WIDTH-1:0] b_center_x;
      logic signed [COORD_WIDTH-1:0] b_center_y;
      logic        [SIZE_WIDTH-1:0]  b_width;
      logic        [SIZE_WIDTH-1:0]  b_height;
   } req_type;

   typedef struct packed {
      logic                          overlap;
      logic        [2:0]             push_side;
      logic signed [COORD_WIDTH-1:0] target_x;
      logic signed [COORD_WIDTH-1:0] target_y;
   } rsp_type;

   // Front end to resolve stage: products, overlap and offsets
   typedef struct packed {
      logic                          hit;
      logic signed [PROD_WIDTH-1:0]  lhs;
      logic signed [PROD_WIDTH-1:0]  rhs;
      logic        [SIZE_WIDTH:0]    off_x;
      logic        [SIZE_WIDTH:0]    off_y;
      logic signed [COORD_WIDTH-1:0] ax;
      logic signed [COORD_WIDTH-1:0] ay;
      logic signed [COORD_WIDTH-1:0] bx;
      logic signed [COORD_WIDTH-1:0] by;
   } prod_type;

   // Clamp a raw target into the signed coordinate range
   function automatic logic signed [COORD_WIDTH-1:0] sat_coord(
      input logic signed [RAW_WIDTH-1:0] v);
      logic signed [COORD_WIDTH-1:0] r;
      if (v[RAW_WIDTH-1:COORD_WIDTH-1] != {(RAW_WIDTH-COORD_WIDTH+1){v[RAW_WIDTH-1]}}) begin
         r = v[RAW_WIDTH-1] ? {1'b1, {(COORD_WIDTH-1){1'b0}}}
                            : {1'b0, {(COORD_WIDTH-1){1'b1}}};
      end else begin
         r = v[COORD_WIDTH-1:0];
      end
      return r;
   endfunction

endpackage

>>> src/bcpo_front.sv
// Front end of the push-out pipeline: center differences, size sums,
// overlap test and the two sector cross products. Depends on bcpo_pkg.
module bcpo_front (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                in_valid,
   input  bcpo_pkg::req_type                   in_data,
   input  logic [bcpo_pkg::SIZE_WIDTH-1:0]     pad,
   output logic                                out_valid,
   output bcpo_pkg::prod_type                  out_data
);

   // Stage 1 registers
   logic                                   v1_ff, v1_in;
   logic signed [bcpo_pkg::DIFF_WIDTH-1:0] dx_ff, dx_in;
   logic signed [bcpo_pkg::DIFF_WIDTH-1:0] dy_ff, dy_in;
   logic        [bcpo_pkg::SIZE_WIDTH:0]   sum_w_ff, sum_w_in;
   logic        [bcpo_pkg::SIZE_WIDTH:0]   sum_h_ff, sum_h_in;
   logic        [bcpo_pkg::SIZE_WIDTH-1:0] aw_ff;
   logic        [bcpo_pkg::SIZE_WIDTH-1:0] ah_ff;
   logic signed [bcpo_pkg::COORD_WIDTH-1:0] ax_ff, ay_ff, bx_ff, by_ff;

   // Stage 2 registers
   logic                v2_ff, v2_in;
   bcpo_pkg::prod_type  s2_ff, s2_in;

   // Stage 1: differences and size sums
   always_comb begin
      v1_in    = in_valid;
      dx_in    = $signed({in_data.b_center_x[bcpo_pkg::COORD_WIDTH-1], in_data.b_center_x})
               - $signed({in_data.a_center_x[bcpo_pkg::COORD_WIDTH-1], in_data.a_center_x});
      dy_in    = $signed({in_data.b_center_y[bcpo_pkg::COORD_WIDTH-1], in_data.b_center_y})
               - $signed({in_data.a_center_y[bcpo_pkg::COORD_WIDTH-1], in_data.a_center_y});
      sum_w_in = {1'b0, in_data.a_width} + {1'b0, in_data.b_width};
      sum_h_in = {1'b0, in_data.a_height} + {1'b0, in_data.b_height};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
      end
      dx_ff    <= dx_in;
      dy_ff    <= dy_in;
      sum_w_ff <= sum_w_in;
      sum_h_ff <= sum_h_in;
      aw_ff    <= in_data.a_width;
      ah_ff    <= in_data.a_height;
      ax_ff    <= in_data.a_center_x;
      ay_ff    <= in_data.a_center_y;
      bx_ff    <= in_data.b_center_x;
      by_ff    <= in_data.b_center_y;
   end

   // Stage 2: overlap test, cross products, push offsets
   always_comb begin
      logic        [bcpo_pkg::DIFF_WIDTH-1:0]  mag_dx;
      logic        [bcpo_pkg::DIFF_WIDTH-1:0]  mag_dy;
      logic signed [bcpo_pkg::SIZE_WIDTH:0]    aw_s;
      logic signed [bcpo_pkg::SIZE_WIDTH:0]    ah_s;
      mag_dx = dx_ff[bcpo_pkg::DIFF_WIDTH-1] ? -dx_ff : dx_ff;
      mag_dy = dy_ff[bcpo_pkg::DIFF_WIDTH-1] ? -dy_ff : dy_ff;
      aw_s   = $signed({1'b0, aw_ff});
      ah_s   = $signed({1'b0, ah_ff});
      v2_in  = v1_ff;
      s2_in.hit   = ({mag_dx, 1'b0} < {2'b00, sum_w_ff}) && ({mag_dy, 1'b0} < {2'b00, sum_h_ff});
      s2_in.lhs   = bcpo_pkg::PROD_WIDTH'(dy_ff) * bcpo_pkg::PROD_WIDTH'(aw_s);
      s2_in.rhs   = bcpo_pkg::PROD_WIDTH'(ah_s) * bcpo_pkg::PROD_WIDTH'(dx_ff);
      s2_in.off_x = {1'b0, pad} + {1'b0, sum_w_ff[bcpo_pkg::SIZE_WIDTH:1]};
      s2_in.off_y = {1'b0, pad} + {1'b0, sum_h_ff[bcpo_pkg::SIZE_WIDTH:1]};
      s2_in.ax    = ax_ff;
      s2_in.ay    = ay_ff;
      s2_in.bx    = bx_ff;
      s2_in.by    = by_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else begin
         v2_ff <= v2_in;
      end
      s2_ff <= s2_in;
   end

   assign out_valid = v2_ff;
   assign out_data  = s2_ff;

endmodule

>>> src/bcpo_resolve.sv
// Back end of the push-out pipeline: sector decision, target add and
// saturation into the result register. Depends on bcpo_pkg.
module bcpo_resolve (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   input  bcpo_pkg::prod_type  in_data,
   output logic                out_valid,
   output bcpo_pkg::rsp_type   out_data
);

   // Stage 3 registers
   logic                                   v3_ff, v3_in;
   logic                                   hit_ff, hit_in;
   logic [2:0]                             side_ff, side_in;
   logic signed [bcpo_pkg::RAW_WIDTH-1:0]  raw_x_ff, raw_x_in;
   logic signed [bcpo_pkg::RAW_WIDTH-1:0]  raw_y_ff, raw_y_in;

   // Stage 4 registers
   logic                v4_ff, v4_in;
   bcpo_pkg::rsp_type   rsp_ff, rsp_in;

   // Stage 3: pick the sector and form the unsaturated target
   always_comb begin
      logic signed [bcpo_pkg::PROD_WIDTH:0]   lhs_x;
      logic signed [bcpo_pkg::PROD_WIDTH:0]   neg_rhs;
      logic                                   u;
      logic                                   v;
      logic signed [bcpo_pkg::RAW_WIDTH-1:0]  ax_r, ay_r, bx_r, by_r;
      logic signed [bcpo_pkg::RAW_WIDTH-1:0]  ox_r, oy_r;
      lhs_x   = $signed({in_data.lhs[bcpo_pkg::PROD_WIDTH-1], in_data.lhs});
      neg_rhs = -$signed({in_data.rhs[bcpo_pkg::PROD_WIDTH-1], in_data.rhs});
      u       = in_data.lhs >= in_data.rhs;
      v       = lhs_x >= neg_rhs;
      ax_r    = bcpo_pkg::RAW_WIDTH'(in_data.ax);
      ay_r    = bcpo_pkg::RAW_WIDTH'(in_data.ay);
      bx_r    = bcpo_pkg::RAW_WIDTH'(in_data.bx);
      by_r    = bcpo_pkg::RAW_WIDTH'(in_data.by);
      ox_r    = $signed({2'b00, in_data.off_x});
      oy_r    = $signed({2'b00, in_data.off_y});
      v3_in   = in_valid;
      hit_in  = in_data.hit;
      side_in = bcpo_pkg::SIDE_NONE;
      raw_x_in = bx_r;
      raw_y_in = by_r;
      if (in_data.hit) begin
         if (u && v) begin
            side_in  = bcpo_pkg::SIDE_ABOVE;
            raw_y_in = ay_r + oy_r;
         end else if (u) begin
            side_in  = bcpo_pkg::SIDE_LEFT;
            raw_x_in = ax_r - ox_r;
         end else if (v) begin
            side_in  = bcpo_pkg::SIDE_RIGHT;
            raw_x_in = ax_r + ox_r;
         end else begin
            side_in  = bcpo_pkg::SIDE_BELOW;
            raw_y_in = ay_r - oy_r;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else begin
         v3_ff <= v3_in;
      end
      hit_ff   <= hit_in;
      side_ff  <= side_in;
      raw_x_ff <= raw_x_in;
      raw_y_ff <= raw_y_in;
   end

   // Stage 4: saturate into the result register
   always_comb begin
      v4_in            = v3_ff;
      rsp_in.overlap   = hit_ff;
      rsp_in.push_side = side_ff;
      rsp_in.target_x  = bcpo_pkg::sat_coord(raw_x_ff);
      rsp_in.target_y  = bcpo_pkg::sat_coord(raw_y_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
      end else begin
         v4_ff <= v4_in;
      end
      rsp_ff <= rsp_in;
   end

   assign out_valid = v4_ff;
   assign out_data  = rsp_ff;

   // A result appears in the cycle after its stage 3 item
   a_valid_chain: assert property (@(posedge clock) disable iff (reset)
      out_valid |-> $past(v3_ff))
      else $error("result strobe without a stage 3 item");

   // No push side without an overlap, and always one with it
   a_side_matches_hit: assert property (@(posedge clock) disable iff (reset)
      out_valid |-> (out_data.overlap == (out_data.push_side != bcpo_pkg::SIDE_NONE)))
      else $error("push side disagrees with overlap");

endmodule

>>> src/box_collision_push_out.sv
// Box collision push-out top level, built on bcpo_pkg, bcpo_front and bcpo_resolve.
// An accepted transfer gives its result on rsp_strobe after passing through the
// four register stages (differences, products, sector, saturate). Throughput: one
// box pair per cycle; busy stays low and all stages run in flight.
// Reset (synchronous, active high) clears all stage valid bits and sets
// push_padding to 0.1 in Q7.8. Results cannot be held off by the receiver.
module box_collision_push_out (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  bcpo_pkg::req_type                 req_data,
   output logic                              rsp_strobe,
   output bcpo_pkg::rsp_type                 rsp_data,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [bcpo_pkg::SIZE_WIDTH-1:0]   csr_data
);

   logic [bcpo_pkg::SIZE_WIDTH-1:0] pad_ff, pad_in;
   logic                            accept;
   logic                            mid_valid;
   bcpo_pkg::prod_type              mid_data;

   // Pipeline never stalls
   assign busy      = 1'b0;
   assign csr_ready = 1'b1;
   assign accept    = start && !busy;

   // Padding register
   always_comb begin
      pad_in = pad_ff;
      if (csr_valid && csr_ready) begin
         pad_in = csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pad_ff <= bcpo_pkg::PAD_RESET;
      end else begin
         pad_ff <= pad_in;
      end
   end

   bcpo_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (accept),
      .in_data   (req_data),
      .pad       (pad_ff),
      .out_valid (mid_valid),
      .out_data  (mid_data)
   );

   bcpo_resolve u_resolve (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (mid_valid),
      .in_data   (mid_data),
      .out_valid (rsp_strobe),
      .out_data  (rsp_data)
   );

   // Every accepted transfer comes out on rsp_strobe
   a_latency: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##4 rsp_strobe)
      else $error("accepted item lost in pipeline");

   // No result without a matching accepted transfer
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(accept, 4))
      else $error("result strobe without an accepted item");

endmodule

>>> tb/bcpo_push_checker.sv
// Scoreboard for the box collision push-out block: watches the command, result
// and padding channels, predicts each result and compares it field by field.
// Depends on bcpo_pkg for the payload types, widths and push side codes.
module bcpo_push_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic                            busy,
   input  bcpo_pkg::req_type               req_data,
   input  logic                            rsp_strobe,
   input  bcpo_pkg::rsp_type               rsp_data,
   input  logic                            csr_valid,
   input  logic                            csr_ready,
   input  logic [bcpo_pkg::SIZE_WIDTH-1:0] csr_data,
   output int                              fail_count,
   output int                              pending,
   output int                              result_count,
   output int                              overlap_count
);

   bcpo_pkg::rsp_type                 push_results_q[$];
   logic [bcpo_pkg::SIZE_WIDTH-1:0]   padding;
   int                                errors = 0;
   int                                results = 0;
   int                                overlaps = 0;

   initial begin
      fail_count    = 0;
      pending       = 0;
      result_count  = 0;
      overlap_count = 0;
      padding       = bcpo_pkg::PAD_RESET;
   end

   // Clamp to the signed coordinate range
   function automatic logic signed [bcpo_pkg::COORD_WIDTH-1:0] clamp_coord(input longint v);
      longint hi, lo;
      hi = (longint'(1) <<< (bcpo_pkg::COORD_WIDTH - 1)) - 1;
      lo = -hi - 1;
      if (v > hi) begin
         v = hi;
      end else if (v < lo) begin
         v = lo;
      end
      return bcpo_pkg::COORD_WIDTH'(v);
   endfunction

   // Overlap test, diagonal sector of A holding B's center, push-out target
   function automatic bcpo_pkg::rsp_type predict_push_out(
      input bcpo_pkg::req_type p,
      input logic [bcpo_pkg::SIZE_WIDTH-1:0] pad);
      longint  ax, ay, aw, ah, bx, by, bw, bh, dx, dy, lhs, rhs, tx, ty, padv;
      logic    upper_left, upper_right;
      bcpo_pkg::rsp_type r;
      ax   = $signed(p.a_center_x);
      ay   = $signed(p.a_center_y);
      aw   = p.a_width;
      ah   = p.a_height;
      bx   = $signed(p.b_center_x);
      by   = $signed(p.b_center_y);
      bw   = p.b_width;
      bh   = p.b_height;
      padv = pad;
      dx   = bx - ax;
      dy   = by - ay;
      tx   = bx;
      ty   = by;
      r.overlap   = (2 * (dx < 0 ? -dx : dx) < aw + bw) &&
                    (2 * (dy < 0 ? -dy : dy) < ah + bh);
      r.push_side = bcpo_pkg::SIDE_NONE;
      if (r.overlap) begin
         // cross-multiplied diagonal tests, no division
         lhs         = dy * aw;
         rhs         = ah * dx;
         upper_left  = lhs >= rhs;
         upper_right = lhs >= -rhs;
         if (upper_left && upper_right) begin
            r.push_side = bcpo_pkg::SIDE_ABOVE;
            ty = ay + padv + ((ah + bh) >>> 1);
         end else if (upper_left) begin
            r.push_side = bcpo_pkg::SIDE_LEFT;
            tx = ax - padv - ((aw + bw) >>> 1);
         end else if (upper_right) begin
            r.push_side = bcpo_pkg::SIDE_RIGHT;
            tx = ax + padv + ((aw + bw) >>> 1);
         end else begin
            r.push_side = bcpo_pkg::SIDE_BELOW;
            ty = ay - padv - ((ah + bh) >>> 1);
         end
      end
      r.target_x = clamp_coord(tx);
      r.target_y = clamp_coord(ty);
      return r;
   endfunction

   task automatic check_field(input string field, input logic signed [31:0] want,
                              input logic signed [31:0] got);
      if (want !== got) begin
         errors++;
         $display("%0t: %s expected %0d actual %0d", $time, field, want, got);
      end
   endtask

   // Track padding writes, queue predictions, compare results in order
   always @(posedge clock) begin : track_push
      bcpo_pkg::rsp_type want;
      if (reset) begin
         push_results_q.delete();
         padding = bcpo_pkg::PAD_RESET;
      end else begin
         if (csr_valid && csr_ready)
            padding = csr_data;
         if (start && !busy)
            push_results_q.push_back(predict_push_out(req_data, padding));
         if (rsp_strobe) begin
            results++;
            if (rsp_data.overlap)
               overlaps++;
            if (push_results_q.size() == 0) begin
               errors++;
               $display("%0t: result with no transfer pending, expected none actual %h",
                        $time, rsp_data);
            end else begin
               want = push_results_q.pop_front();
               check_field("overlap", want.overlap, rsp_data.overlap);
               check_field("push_side", want.push_side, rsp_data.push_side);
               check_field("target_x", $signed(want.target_x), $signed(rsp_data.target_x));
               check_field("target_y", $signed(want.target_y), $signed(rsp_data.target_y));
            end
         end
      end
      fail_count    <= errors;
      pending       <= push_results_q.size();
      result_count  <= results;
      overlap_count <= overlaps;
   end

endmodule

>>> tb/tb_box_collision_push_out.sv
// Testbench top for box_collision_push_out: drives box pairs and padding writes,
// instantiates the block beside bcpo_push_checker and reports the verdict.
// Depends on bcpo_pkg, box_collision_push_out and bcpo_push_checker.
module tb_box_collision_push_out;

   localparam int CYCLE_LIMIT  = 200000;
   localparam int DRAIN_CYCLES = 8;

   logic                            clock;
   logic                            reset;
   logic                            start;
   logic                            busy;
   bcpo_pkg::req_type               req_data;
   logic                            rsp_strobe;
   bcpo_pkg::rsp_type               rsp_data;
   logic                            csr_valid;
   logic                            csr_ready;
   logic [bcpo_pkg::SIZE_WIDTH-1:0] csr_data;

   int fail_count;
   int pending;
   int result_count;
   int overlap_count;
   int cycle_count = 0;
   int pairs_sent = 0;
   int last_padding = 0;

   box_collision_push_out u_top (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   bcpo_push_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_data      (req_data),
      .rsp_strobe    (rsp_strobe),
      .rsp_data      (rsp_data),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_data      (csr_data),
      .fail_count    (fail_count),
      .pending       (pending),
      .result_count  (result_count),
      .overlap_count (overlap_count)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("box_collision_push_out: mismatch");
         $finish;
      end
   end

   function automatic bcpo_pkg::req_type make_pair(input int ax, input int ay, input int aw,
                                                   input int ah, input int bx, input int by,
                                                   input int bw, input int bh);
      bcpo_pkg::req_type p;
      p.a_center_x = bcpo_pkg::COORD_WIDTH'(ax);
      p.a_center_y = bcpo_pkg::COORD_WIDTH'(ay);
      p.a_width    = bcpo_pkg::SIZE_WIDTH'(aw);
      p.a_height   = bcpo_pkg::SIZE_WIDTH'(ah);
      p.b_center_x = bcpo_pkg::COORD_WIDTH'(bx);
      p.b_center_y = bcpo_pkg::COORD_WIDTH'(by);
      p.b_width    = bcpo_pkg::SIZE_WIDTH'(bw);
      p.b_height   = bcpo_pkg::SIZE_WIDTH'(bh);
      return p;
   endfunction

   // Mostly small boxes, some huge ones to reach saturation
   function automatic int random_size();
      case ($urandom_range(0, 9))
         0:       return 32767;
         1, 2:    return int'($urandom_range(1, 32767));
         default: return int'($urandom_range(1, 600));
      endcase
   endfunction

   // Full range, with extra weight near both ends
   function automatic int random_center();
      case ($urandom_range(0, 7))
         0:       return 32767 - int'($urandom_range(0, 255));
         1:       return -32768 + int'($urandom_range(0, 255));
         default: return int'($urandom_range(0, 65535)) - 32768;
      endcase
   endfunction

   // Coordinate for B that overlaps A on one axis, sometimes exactly touching
   function automatic int near_coord(input int a, input int span);
      int half, d, v;
      half = (span - 1) / 2;
      if ($urandom_range(0, 9) == 0)
         d = $urandom_range(0, 1) ? span / 2 : -(span / 2);
      else
         d = int'($urandom_range(0, 2 * half)) - half;
      v = a + d;
      if (v > 32767)
         v = 32767;
      else if (v < -32768)
         v = -32768;
      return v;
   endfunction

   function automatic bcpo_pkg::req_type random_pair();
      int ax, ay, aw, ah, bx, by, bw, bh;
      aw = random_size();
      ah = random_size();
      bw = random_size();
      bh = random_size();
      ax = random_center();
      ay = random_center();
      if ($urandom_range(0, 99) < 75) begin
         bx = near_coord(ax, aw + bw);
         by = near_coord(ay, ah + bh);
      end else begin
         bx = random_center();
         by = random_center();
      end
      return make_pair(ax, ay, aw, ah, bx, by, bw, bh);
   endfunction

   task automatic idle_gap(input int idle_pct);
      while (int'($urandom_range(0, 99)) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
   endtask

   // Hold start until the block takes the transfer
   task automatic send_pair(input bcpo_pkg::req_type p);
      start    <= 1'b1;
      req_data <= p;
      @(posedge clock);
      while (busy)
         @(posedge clock);
      pairs_sent++;
   endtask

   // Stop sending and wait for every outstanding result
   task automatic drain();
      start <= 1'b0;
      @(posedge clock);
      while (pending != 0)
         @(posedge clock);
   endtask

   task automatic write_padding(input logic [bcpo_pkg::SIZE_WIDTH-1:0] v);
      csr_valid <= 1'b1;
      csr_data  <= v;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      csr_valid    <= 1'b0;
      last_padding = int'(v);
   endtask

   task automatic run_phase(input int count, input int idle_pct);
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(0, 199) == 0)
            drain();
         idle_gap(idle_pct);
         send_pair(random_pair());
      end
      drain();
   endtask

   initial begin
      reset     <= 1'b1;
      start     <= 1'b0;
      req_data  <= '0;
      csr_valid <= 1'b0;
      csr_data  <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed pairs at the reset padding
      send_pair(make_pair(0, 0, 256, 256, 0, 0, 256, 256));        // equal centers
      send_pair(make_pair(0, 0, 512, 256, 0, 100, 256, 256));      // above
      send_pair(make_pair(0, 0, 512, 256, 0, -100, 256, 256));     // below
      send_pair(make_pair(0, 0, 512, 256, -300, 0, 256, 256));     // left
      send_pair(make_pair(0, 0, 512, 256, 300, 0, 256, 256));      // right
      send_pair(make_pair(0, 0, 256, 256, 100, 100, 256, 256));    // upper diagonal tie
      send_pair(make_pair(0, 0, 256, 256, -100, -100, 256, 256));  // lower left diagonal
      send_pair(make_pair(0, 0, 256, 256, 100, -100, 256, 256));   // lower right diagonal
      send_pair(make_pair(0, 0, 256, 256, 256, 0, 256, 256));      // touching in x
      send_pair(make_pair(0, 0, 256, 256, 0, -256, 256, 256));     // touching in y
      send_pair(make_pair(0, 0, 256, 256, 255, 0, 256, 256));      // just inside
      send_pair(make_pair(-5000, 4000, 100, 100, 6000, -7000, 100, 100)); // far apart
      send_pair(make_pair(0, 0, 0, 256, 10, 0, 64, 64));           // zero width A, dx > 0
      send_pair(make_pair(0, 0, 0, 256, -10, 0, 64, 64));          // zero width A, dx < 0
      send_pair(make_pair(0, 0, 0, 256, 0, 20, 64, 64));           // zero width A, dx = 0
      send_pair(make_pair(0, 0, 0, 0, 0, 0, 0, 0));                // all sizes zero
      send_pair(make_pair(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767));
      send_pair(make_pair(-32768, -32668, 32767, 32767, -32768, -32768, 32767, 32767));
      send_pair(make_pair(-32668, -32768, 32767, 32767, -32768, -32768, 32767, 32767));
      send_pair(make_pair(32667, 0, 32767, 32767, 32767, 0, 32767, 32767));
      send_pair(make_pair(-32768, -32768, 32767, 32767, 32767, 32767, 32767, 32767));
      send_pair(make_pair(0, 0, 1, 1, 0, 0, 1, 1));                // smallest boxes
      send_pair(make_pair(0, 0, 3, 3, 1, 0, 2, 2));                // odd size sum
      drain();

      // Random phases, each with its own padding and sender idling
      write_padding('0);
      run_phase(340, 15);
      write_padding({bcpo_pkg::SIZE_WIDTH{1'b1}});
      run_phase(330, 62);
      write_padding(bcpo_pkg::SIZE_WIDTH'($urandom_range(1, 32766)));
      run_phase(330, 0);

      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Sent %0d box pairs under paddings 26, 0, 32767 and %0d, sender idle 15/62/0%%.",
               pairs_sent, last_padding);
      $display("Checked %0d results, %0d of them overlapping.", result_count, overlap_count);
      if (fail_count == 0 && pending == 0)
         $display("box_collision_push_out: match");
      else
         $display("box_collision_push_out: mismatch");
      $finish;
   end

endmodule
